/* rtl/physical_page_allocator_assert.svh */
// Assertion macros for the checker file.
`ifndef PHYSICAL_PAGE_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppa assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppa assertion failed");

`endif

/* rtl/ppa_pkg.sv */
`timescale 1ns / 1ps
package ppa_pkg;

  // Fixed field widths of the request and response
  localparam int FUNC_W  = 3;
  localparam int PID_W   = 8;
  localparam int PAGE_FW = 12;
  localparam int COUNT_W = 13;

  // Default sizing
  localparam int NUM_PAGES_DEF = 4096;
  localparam int ID_BITS_DEF   = 8;
  localparam int REF_BITS_DEF  = 8;
  localparam logic [PID_W-1:0] ORPHAN_RST = 8'd255;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC      = 3'd0,
    FN_FREE_ONE   = 3'd1,
    FN_FREE_RUN   = 3'd2,
    FN_FREE_OWNER = 3'd3,
    FN_TRANSFER   = 3'd4,
    FN_SHARE      = 3'd5,
    FN_RESERVE    = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_PASS,
    S_DONE
  } state_t;

  // Status of one entry update
  typedef struct packed {
    logic we;
    logic inc;
    logic dec;
    logic hit;
  } alu_flags_t;

endpackage

/* rtl/ppa_req_if.sv */
`timescale 1ns / 1ps
interface ppa_req_if;
  logic                        valid;
  logic                        ready;
  logic [ppa_pkg::FUNC_W-1:0]  func;
  logic [ppa_pkg::PID_W-1:0]   pid;
  logic [ppa_pkg::PAGE_FW-1:0] page;
  logic [ppa_pkg::COUNT_W-1:0] count;

  modport source (output valid, func, pid, page, count, input ready);
  modport sink   (input valid, func, pid, page, count, output ready);
endinterface

/* rtl/ppa_rsp_if.sv */
`timescale 1ns / 1ps
interface ppa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [ppa_pkg::PAGE_FW-1:0] result_page;
  logic [ppa_pkg::COUNT_W-1:0] pages_in_use;

  modport source (output valid, ok, result_page, pages_in_use, input ready);
  modport sink   (input valid, ok, result_page, pages_in_use, output ready);
endinterface

/* rtl/ppa_cfg_if.sv */
`timescale 1ns / 1ps
interface ppa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ppa_pkg::PID_W-1:0] orphan_id;

  modport source (output valid, orphan_id, input ready);
  modport sink   (input valid, orphan_id, output ready);
endinterface

/* rtl/ppa_ram.sv */
`timescale 1ns / 1ps
module ppa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/ppa_entry_alu.sv */
`timescale 1ns / 1ps
module ppa_entry_alu #(
  parameter int ID_BITS  = ppa_pkg::ID_BITS_DEF,
  parameter int REF_BITS = ppa_pkg::REF_BITS_DEF
) (
  input  ppa_pkg::func_t                 op,
  input  logic [ID_BITS+REF_BITS:0]      ent_i,
  input  logic [ID_BITS-1:0]             pid,
  input  logic [ID_BITS-1:0]             orphan,
  output logic [ID_BITS+REF_BITS:0]      ent_o,
  output ppa_pkg::alu_flags_t            flags
);
  import ppa_pkg::*;

  localparam int EW = ID_BITS + REF_BITS + 1;

  logic                u, nu;
  logic [ID_BITS-1:0]  o, no;
  logic [REF_BITS-1:0] r, nr, r_up;
  logic                last_ref;

  // Update one page entry for the current operation
  always_comb begin
    u        = ent_i[EW-1];
    o        = ent_i[REF_BITS +: ID_BITS];
    r        = ent_i[REF_BITS-1:0];
    r_up     = (&r) ? r : r + REF_BITS'(1);
    last_ref = r <= REF_BITS'(1);
    nu       = u;
    no       = o;
    nr       = r;
    flags    = '0;
    unique case (op)
      FN_ALLOC: begin
        nu = 1'b1; no = pid; nr = r_up;
        flags.we = 1'b1; flags.inc = 1'b1;
      end
      FN_FREE_ONE, FN_FREE_RUN: begin
        if (u && o != '0) begin
          flags.we = 1'b1;
          if (last_ref) begin
            nu = 1'b0; no = '0; nr = '0; flags.dec = 1'b1;
          end else begin
            nr = r - REF_BITS'(1);
          end
        end
      end
      FN_FREE_OWNER: begin
        if (u && o == pid) begin
          flags.we = 1'b1;
          if (last_ref) begin
            nu = 1'b0; no = '0; nr = '0; flags.dec = 1'b1;
          end else begin
            no = orphan; nr = r - REF_BITS'(1);
          end
        end
      end
      FN_TRANSFER: begin
        if (u) begin
          no = pid; flags.we = 1'b1; flags.hit = 1'b1;
        end
      end
      FN_SHARE: begin
        if (u) begin
          nr = r_up; flags.we = 1'b1; flags.hit = 1'b1;
        end
      end
      FN_RESERVE: begin
        flags.we = 1'b1; flags.inc = !u;
        nu = 1'b1; no = '0; nr = r_up;
      end
      default: begin
      end
    endcase
    ent_o = {nu, no, nr};
  end
endmodule

/* rtl/physical_page_allocator.sv */
`timescale 1ns / 1ps
// Physical page allocator: in-use bit, owner id and reference count per page.
// in_ch carries one request (func, pid, page, count); out_ch returns one
// response (ok, result_page, pages_in_use) per request; cfg_ch writes the
// orphan owner id and is always ready.
// All page state sits in one RAM word per page, walked by one address
// sequencer feeding a shared entry update unit, one page per cycle.
// Single-page requests walk one page; free-by-owner walks all NUM_PAGES;
// alloc runs a search walk of up to all pages, then a fill walk over count
// pages; free run and reserve walk the span. One request at a time:
// in_ch.ready is high only while idle.
// After reset a clearing walk writes every one of the NUM_PAGES entries
// (4096 by default) to zero; no request is taken meanwhile.
// The response sits in an output register; a stalled receiver holds it and
// the next request is taken, but its response waits until the slot frees.
module physical_page_allocator #(
  parameter int NUM_PAGES = ppa_pkg::NUM_PAGES_DEF,
  parameter int ID_BITS   = ppa_pkg::ID_BITS_DEF,
  parameter int REF_BITS  = ppa_pkg::REF_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ppa_req_if.sink   in_ch,
  ppa_rsp_if.source out_ch,
  ppa_cfg_if.sink   cfg_ch
);
  import ppa_pkg::*;

  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int NUM_W  = $clog2(NUM_PAGES + 1);
  localparam int LEN_W  = (NUM_W > COUNT_W) ? NUM_W : COUNT_W;
  localparam int EW     = ID_BITS + REF_BITS + 1;

  state_t              state_r, state_nxt;
  func_t               op_r, op_nxt;
  logic [ID_BITS-1:0]  pid_r, pid_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [ID_BITS-1:0]  orphan_r, orphan_nxt;
  logic [NUM_W-1:0]    used_r, used_nxt;
  logic [PAGE_W-1:0]   addr_r, addr_nxt;
  logic [LEN_W-1:0]    left_r, left_nxt;
  logic                pv_r, pv_nxt;
  logic [PAGE_W-1:0]   paddr_r, paddr_nxt;
  logic [LEN_W-1:0]    run_r, run_nxt;
  logic                ok_r, ok_nxt;
  logic [PAGE_FW-1:0]  res_r, res_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic                ook_r, ook_nxt;
  logic [PAGE_FW-1:0]  ores_r, ores_nxt;
  logic [COUNT_W-1:0]  oused_r, oused_nxt;

  logic                in_acc, issue, slot_free;
  logic [ID_BITS-1:0]  in_pid;
  logic [LEN_W-1:0]    page_x, cnt_x, avail, span, free_x;
  logic                page_lt;
  logic                st_search, st_pass, st_ok;
  logic [PAGE_FW-1:0]  st_res;
  logic [PAGE_W-1:0]   st_addr;
  logic [LEN_W-1:0]    st_len;
  logic                found;
  logic [LEN_W-1:0]    first_x;
  logic [PAGE_W-1:0]   first_a;

  logic                ram_we, ram_re;
  logic [PAGE_W-1:0]   ram_waddr;
  logic [EW-1:0]       ram_wdata, ram_rdata, alu_ent;
  alu_flags_t          alu_flags;

  ppa_ram #(.WIDTH(EW), .DEPTH(NUM_PAGES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  ppa_entry_alu #(.ID_BITS(ID_BITS), .REF_BITS(REF_BITS)) u_alu (
    .op     (op_r),
    .ent_i  (ram_rdata),
    .pid    (pid_r),
    .orphan (orphan_r),
    .ent_o  (alu_ent),
    .flags  (alu_flags)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.ok           = ook_r;
  assign out_ch.result_page  = ores_r;
  assign out_ch.pages_in_use = oused_r;

  assign in_acc    = in_ch.valid && (state_r == S_IDLE);
  assign issue     = (state_r == S_SEARCH || state_r == S_PASS) && left_r != '0;
  assign slot_free = !ovalid_r || out_ch.ready;

  // Decode a new request: checks, start page and walk length
  always_comb begin
    in_pid  = ID_BITS'(in_ch.pid);
    page_x  = LEN_W'(in_ch.page);
    cnt_x   = LEN_W'(in_ch.count);
    page_lt = page_x < LEN_W'(NUM_PAGES);
    avail   = LEN_W'(NUM_PAGES) - page_x;
    span    = page_lt ? ((cnt_x < avail) ? cnt_x : avail) : '0;
    free_x  = LEN_W'(NUM_PAGES) - LEN_W'(used_r);
    st_search = 1'b0;
    st_pass   = 1'b0;
    st_ok     = 1'b0;
    st_res    = '0;
    st_addr   = page_x[PAGE_W-1:0];
    st_len    = LEN_W'(1);
    unique case (func_t'(in_ch.func))
      FN_ALLOC: begin
        st_search = (in_pid != orphan_r) && (cnt_x != '0) && (cnt_x <= free_x);
        st_addr   = '0;
        st_len    = LEN_W'(NUM_PAGES);
      end
      FN_FREE_ONE: begin
        st_ok   = 1'b1;
        st_pass = page_lt;
      end
      FN_FREE_RUN: begin
        st_ok   = 1'b1;
        st_pass = span != '0;
        st_len  = span;
      end
      FN_FREE_OWNER: begin
        st_ok   = 1'b1;
        st_pass = in_pid != '0;
        st_addr = '0;
        st_len  = LEN_W'(NUM_PAGES);
      end
      FN_TRANSFER: begin
        st_pass = (in_ch.page != '0) && page_lt && (in_pid != '0);
      end
      FN_SHARE: begin
        st_pass = page_lt;
      end
      FN_RESERVE: begin
        st_ok   = 1'b1;
        st_res  = in_ch.page;
        st_pass = span != '0;
        st_len  = span;
      end
      default: begin
      end
    endcase
  end

  // First-fit run detection on the read word
  always_comb begin
    found   = !ram_rdata[EW-1] && (run_r + LEN_W'(1) == LEN_W'(count_r));
    first_x = LEN_W'(paddr_r) + LEN_W'(1) - LEN_W'(count_r);
    first_a = first_x[PAGE_W-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (left_r == LEN_W'(1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (st_search) state_nxt = S_SEARCH;
          else if (st_pass) state_nxt = S_PASS;
          else state_nxt = S_DONE;
        end
      end
      S_SEARCH: begin
        if (pv_r && found) state_nxt = S_PASS;
        else if (left_r == '0 && !pv_r) state_nxt = S_DONE;
      end
      S_PASS: if (left_r == '0 && !pv_r) state_nxt = S_DONE;
      S_DONE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Datapath and sequencer outputs
  always_comb begin
    op_nxt     = op_r;
    pid_nxt    = pid_r;
    count_nxt  = count_r;
    orphan_nxt = cfg_ch.valid ? ID_BITS'(cfg_ch.orphan_id) : orphan_r;
    used_nxt   = used_r;
    addr_nxt   = addr_r;
    left_nxt   = left_r;
    pv_nxt     = 1'b0;
    paddr_nxt  = paddr_r;
    run_nxt    = run_r;
    ok_nxt     = ok_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ook_nxt    = ook_r;
    ores_nxt   = ores_r;
    oused_nxt  = oused_r;
    ram_we     = 1'b0;
    ram_waddr  = paddr_r;
    ram_wdata  = alu_ent;
    ram_re     = issue;

    // advance the walk address
    if (issue) begin
      addr_nxt  = addr_r + PAGE_W'(1);
      left_nxt  = left_r - LEN_W'(1);
      pv_nxt    = 1'b1;
      paddr_nxt = addr_r;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = '0;
        addr_nxt  = addr_r + PAGE_W'(1);
        left_nxt  = left_r - LEN_W'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = func_t'(in_ch.func);
          pid_nxt   = in_pid;
          count_nxt = in_ch.count;
          ok_nxt    = st_ok;
          res_nxt   = st_res;
          addr_nxt  = st_addr;
          left_nxt  = (st_search || st_pass) ? st_len : '0;
          run_nxt   = '0;
        end
      end
      S_SEARCH: begin
        if (pv_r) begin
          run_nxt = ram_rdata[EW-1] ? '0 : run_r + LEN_W'(1);
          // start the fill walk at the run found
          if (found) begin
            addr_nxt = first_a;
            left_nxt = LEN_W'(count_r);
            pv_nxt   = 1'b0;
            ok_nxt   = 1'b1;
            res_nxt  = PAGE_FW'(first_a);
          end
        end
      end
      S_PASS: begin
        if (pv_r) begin
          ram_we = alu_flags.we;
          if (alu_flags.inc) used_nxt = used_r + NUM_W'(1);
          else if (alu_flags.dec && used_r != '0) used_nxt = used_r - NUM_W'(1);
          if (alu_flags.hit) begin
            ok_nxt  = 1'b1;
            res_nxt = PAGE_FW'(paddr_r);
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ook_nxt    = ok_r;
          ores_nxt   = res_r;
          oused_nxt  = COUNT_W'(used_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      orphan_r <= ID_BITS'(ORPHAN_RST);
      used_r   <= '0;
      addr_r   <= '0;
      left_r   <= LEN_W'(NUM_PAGES);
      pv_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      orphan_r <= orphan_nxt;
      used_r   <= used_nxt;
      addr_r   <= addr_nxt;
      left_r   <= left_nxt;
      pv_r     <= pv_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pid_r   <= pid_nxt;
    count_r <= count_nxt;
    paddr_r <= paddr_nxt;
    run_r   <= run_nxt;
    ok_r    <= ok_nxt;
    res_r   <= res_nxt;
    ook_r   <= ook_nxt;
    ores_r  <= ores_nxt;
    oused_r <= oused_nxt;
  end
endmodule

/* rtl/ppa_checker.sv */
`timescale 1ns / 1ps
`include "physical_page_allocator_assert.svh"
module ppa_checker #(
  parameter int NUM_PAGES = ppa_pkg::NUM_PAGES_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_ok,
  input logic [ppa_pkg::PAGE_FW-1:0] out_result_page,
  input logic [ppa_pkg::COUNT_W-1:0] out_pages_in_use
);
  import ppa_pkg::*;

  // Hold a stalled response
  `PPA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  // Busy right after taking a request
  `PPA_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  // Page count never exceeds the page pool
  `PPA_ASSERT_IMP(a_used_bound, out_valid, int'(out_pages_in_use) <= NUM_PAGES)
  // Refusals report page zero
  `PPA_ASSERT_IMP(a_refuse_zero, out_valid && !out_ok, out_result_page == '0)
endmodule

bind physical_page_allocator ppa_checker #(.NUM_PAGES(NUM_PAGES)) u_ppa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_ok           (out_ch.ok),
  .out_result_page  (out_ch.result_page),
  .out_pages_in_use (out_ch.pages_in_use)
);
